FILE: hw/rtl/crrc_pkg.sv
package crrc_pkg;

    // Width of byte offsets and counts on every port and in the state
    localparam int OFFSET_BITS = 20;
    localparam int WORD_BYTES  = 4;
    localparam int WORD_SHIFT  = 2;
    localparam int STATUS_BITS = 4;
    localparam int CMD_BITS    = 2;
    localparam int CFG_IDX_BITS = 2;

    typedef logic [OFFSET_BITS-1:0] offset_t;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_INIT       = 2'd0,
        CMD_RESERVE    = 2'd1,
        CMD_COMMIT     = 2'd2,
        CMD_COMMIT_ALL = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_IN_PLACE   = 4'd0,
        ST_BOUNCE     = 4'd1,
        ST_FULL       = 4'd2,
        ST_TOO_LARGE  = 4'd3,
        ST_MISALIGNED = 4'd4,
        ST_PENDING    = 4'd5,
        ST_COMMITTED  = 4'd6,
        ST_NO_RESERVE = 4'd7,
        ST_INIT_DONE  = 4'd8
    } status_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_RING_MIN        = 2'd0,
        CFG_RING_MAX        = 2'd1,
        CFG_RESERVE_CAPABLE = 2'd2,
        CFG_BOUNCE_BYTES    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        offset_t ring_min;
        offset_t ring_max;
        logic    reserve_capable;
        offset_t bounce_bytes;
    } crrc_cfg_t;

    typedef struct packed {
        offset_t write_pointer;
        offset_t pending_bytes;
        logic    bounce_in_use;
    } crrc_state_t;

    typedef struct packed {
        status_t status;
        offset_t write_offset;
        offset_t next_offset;
        offset_t reserve_announce;
        offset_t first_chunk_bytes;
    } crrc_result_t;

endpackage

FILE: hw/rtl/crrc_step.sv
module crrc_step
    import crrc_pkg::*;
(
    input  crrc_cfg_t    cfg,
    input  crrc_state_t  state,
    input  cmd_t         cmd,
    input  offset_t      byte_count,
    input  offset_t      stop_offset,
    output crrc_state_t  state_next,
    output crrc_result_t result
);

    offset_t                nx;
    offset_t                mn;
    offset_t                mx;
    offset_t                span;
    offset_t                cbytes;
    offset_t                room;
    offset_t                wrapped;
    logic [OFFSET_BITS:0]   sum_res;
    logic [OFFSET_BITS:0]   sum_com;
    logic [OFFSET_BITS+1:0] lhs_wrap;
    logic [OFFSET_BITS+1:0] rhs_wrap;
    logic                   in_place;
    logic                   bounce;
    logic                   too_large;
    logic                   misaligned;

    assign nx = state.write_pointer;
    assign mn = cfg.ring_min;
    assign mx = cfg.ring_max;

    // Reserve: size checks against bounce buffer and ring span
    assign span       = (mx >= mn) ? (mx - mn) : '0;
    assign too_large  = (byte_count > cfg.bounce_bytes) || (byte_count > span);
    assign misaligned = (byte_count[WORD_SHIFT-1:0] != '0);

    // Reserve: room before the consumer stop point, in place or across the wrap
    assign sum_res  = {1'b0, nx} + {1'b0, byte_count};
    assign lhs_wrap = {2'b00, mx} + {2'b00, stop_offset};
    assign rhs_wrap = {2'b00, nx} + {2'b00, mn} + {2'b00, byte_count};

    always_comb
    begin
        in_place = 1'b0;
        bounce   = 1'b0;
        if (nx >= stop_offset)
        begin
            if ((sum_res < {1'b0, mx}) || ((sum_res == {1'b0, mx}) && (stop_offset > mn)))
                in_place = 1'b1;
            else if (lhs_wrap > rhs_wrap)
                bounce = 1'b1;
        end
        else if (sum_res < {1'b0, stop_offset})
        begin
            in_place = 1'b1;
        end
    end

    // Commit: advance with a single wrap, first chunk up to ring end
    assign cbytes  = (cmd == CMD_COMMIT_ALL) ? state.pending_bytes : byte_count;
    assign sum_com = {1'b0, nx} + {1'b0, cbytes};
    assign wrapped = (sum_com >= {1'b0, mx}) ? (sum_com[OFFSET_BITS-1:0] + mn - mx)
                                             : sum_com[OFFSET_BITS-1:0];
    assign room    = (mx > nx) ? (mx - nx) : '0;

    always_comb
    begin
        state_next               = state;
        result.status            = ST_FULL;
        result.write_offset      = '0;
        result.next_offset       = nx;
        result.reserve_announce  = '0;
        result.first_chunk_bytes = '0;
        unique case (cmd)
            CMD_INIT:
            begin
                state_next.write_pointer = mn;
                state_next.pending_bytes = '0;
                state_next.bounce_in_use = 1'b0;
                result.status            = ST_INIT_DONE;
                result.write_offset      = mn;
                result.next_offset       = mn;
            end
            CMD_RESERVE:
            begin
                if (too_large)
                    result.status = ST_TOO_LARGE;
                else if (misaligned)
                    result.status = ST_MISALIGNED;
                else if (state.pending_bytes != '0)
                    result.status = ST_PENDING;
                else if (in_place && (cfg.reserve_capable ||
                         (byte_count <= offset_t'(WORD_BYTES))))
                begin
                    state_next.bounce_in_use = 1'b0;
                    state_next.pending_bytes = byte_count;
                    result.status            = ST_IN_PLACE;
                    result.write_offset      = nx;
                    result.reserve_announce  = cfg.reserve_capable ? byte_count : '0;
                end
                else if (in_place || bounce)
                begin
                    state_next.bounce_in_use = 1'b1;
                    state_next.pending_bytes = byte_count;
                    result.status            = ST_BOUNCE;
                end
                else
                begin
                    result.status = ST_FULL;
                end
            end
            CMD_COMMIT, CMD_COMMIT_ALL:
            begin
                result.write_offset = nx;
                if (state.pending_bytes == '0)
                begin
                    result.status = ST_NO_RESERVE;
                end
                else
                begin
                    state_next.pending_bytes = '0;
                    state_next.write_pointer = wrapped;
                    result.status            = ST_COMMITTED;
                    result.next_offset       = wrapped;
                    if (state.bounce_in_use)
                    begin
                        result.first_chunk_bytes = (cbytes < room) ? cbytes : room;
                        result.reserve_announce  = cfg.reserve_capable ? cbytes : '0;
                    end
                end
            end
            default:
            begin
                result.status = ST_FULL;
            end
        endcase
    end

endmodule

FILE: hw/rtl/command_ring_reserve_commit_top.sv
// Channel   Handshake                    Payload
// item      item_valid / item_ready      cmd, byte_count, stop_offset
// result    result_valid / result_ready  status, write_offset, next_offset,
//                                        reserve_announce, first_chunk_bytes
// cfg       cfg_valid / cfg_ready        cfg_index, cfg_data
//
// One word per cycle while item_ready is high: a command is decoded and the
// ring state updated in the cycle it is accepted; its result is registered in
// the output register, or the skid entry if that is full. A two-entry output queue
// (output register plus skid) decouples the sides; item_ready drops only while
// both entries hold undelivered results. Reset clears the pointer, reservation
// and bounce flag and loads the register defaults; cfg_ready is always high.
module command_ring_reserve_commit_top
    import crrc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    item_valid,
    output logic                    item_ready,
    input  logic [CMD_BITS-1:0]     cmd,
    input  logic [OFFSET_BITS-1:0]  byte_count,
    input  logic [OFFSET_BITS-1:0]  stop_offset,

    output logic                    result_valid,
    input  logic                    result_ready,
    output logic [STATUS_BITS-1:0]  status,
    output logic [OFFSET_BITS-1:0]  write_offset,
    output logic [OFFSET_BITS-1:0]  next_offset,
    output logic [OFFSET_BITS-1:0]  reserve_announce,
    output logic [OFFSET_BITS-1:0]  first_chunk_bytes,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [OFFSET_BITS-1:0]  cfg_data
);

    crrc_cfg_t    cfg_reg;
    crrc_state_t  state_reg;
    crrc_state_t  state_next;
    crrc_result_t step_result;
    crrc_result_t main_reg;
    crrc_result_t skid_reg;
    logic         main_valid_reg;
    logic         skid_valid_reg;
    logic         accept;
    logic         take;

    assign cfg_ready  = 1'b1;
    assign item_ready = !skid_valid_reg;
    assign accept     = item_valid && item_ready;
    assign take       = main_valid_reg && result_ready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ring_min        <= '0;
            cfg_reg.ring_max        <= '1;
            cfg_reg.reserve_capable <= 1'b0;
            cfg_reg.bounce_bytes    <= offset_t'(1024);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_RING_MIN:        cfg_reg.ring_min        <= cfg_data;
                CFG_RING_MAX:        cfg_reg.ring_max        <= cfg_data;
                CFG_RESERVE_CAPABLE: cfg_reg.reserve_capable <= cfg_data[0];
                CFG_BOUNCE_BYTES:    cfg_reg.bounce_bytes    <= cfg_data;
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    crrc_step u_step
    (
        .cfg         (cfg_reg),
        .state       (state_reg),
        .cmd         (cmd_t'(cmd)),
        .byte_count  (byte_count),
        .stop_offset (stop_offset),
        .state_next  (state_next),
        .result      (step_result)
    );

    // Advance ring state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (accept)
            state_reg <= state_next;
    end

    // Hold results in the output register and skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (!accept)
            begin
                main_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (!main_valid_reg)
                main_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (skid_valid_reg)
                main_reg <= skid_reg;
            else if (accept)
                main_reg <= step_result;
        end
        else if (accept)
        begin
            if (!main_valid_reg)
                main_reg <= step_result;
            else
                skid_reg <= step_result;
        end
    end

    assign result_valid      = main_valid_reg;
    assign status            = main_reg.status;
    assign write_offset      = main_reg.write_offset;
    assign next_offset       = main_reg.next_offset;
    assign reserve_announce  = main_reg.reserve_announce;
    assign first_chunk_bytes = main_reg.first_chunk_bytes;

endmodule

FILE: tb/sv/crrc_ring_checker.sv
module crrc_ring_checker
    import crrc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    item_valid,
    input  logic                    item_ready,
    input  logic [CMD_BITS-1:0]     cmd,
    input  logic [OFFSET_BITS-1:0]  byte_count,
    input  logic [OFFSET_BITS-1:0]  stop_offset,

    input  logic                    result_valid,
    input  logic                    result_ready,
    input  logic [STATUS_BITS-1:0]  status,
    input  logic [OFFSET_BITS-1:0]  write_offset,
    input  logic [OFFSET_BITS-1:0]  next_offset,
    input  logic [OFFSET_BITS-1:0]  reserve_announce,
    input  logic [OFFSET_BITS-1:0]  first_chunk_bytes,

    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [OFFSET_BITS-1:0]  cfg_data,

    output int                      mismatches,
    output int                      replies_owed
);

    localparam int REPORT_LIMIT = 10;

    crrc_cfg_t    ring_cfg;
    crrc_state_t  ring_state;
    crrc_result_t replies_due[$];

    // Count a failure; print only the first few
    task automatic note_fault(string what);
        if (mismatches < REPORT_LIMIT)
            $display("%0t ring check: %s", $time, what);
        mismatches = mismatches + 1;
    endtask

    // Advance the shadow ring by one command word and return its reply
    function automatic crrc_result_t advance_ring(cmd_t op, offset_t bytes, offset_t stop);
        crrc_result_t r;
        longint lo, hi, ptr, st, b, span, room, sum;
        offset_t amount;
        logic place, bounce;
        r = '0;
        lo = ring_cfg.ring_min;
        hi = ring_cfg.ring_max;
        ptr = ring_state.write_pointer;
        st = stop;
        b = bytes;
        place = 1'b0;
        bounce = 1'b0;
        case (op)
            CMD_INIT:
            begin
                ring_state.write_pointer = ring_cfg.ring_min;
                ring_state.pending_bytes = '0;
                ring_state.bounce_in_use = 1'b0;
                r.status = ST_INIT_DONE;
                r.write_offset = ring_cfg.ring_min;
                r.next_offset = ring_state.write_pointer;
            end
            CMD_RESERVE:
            begin
                r.next_offset = ring_state.write_pointer;
                span = (hi >= lo) ? hi - lo : 0;
                if (b > longint'(ring_cfg.bounce_bytes) || b > span)
                    r.status = ST_TOO_LARGE;
                else if (bytes % WORD_BYTES != 0)
                    r.status = ST_MISALIGNED;
                else if (ring_state.pending_bytes != 0)
                    r.status = ST_PENDING;
                else
                begin
                    // Decide in place, bounce or full; one word stays free
                    if (ptr >= st)
                    begin
                        if (ptr + b < hi || (ptr + b == hi && st > lo))
                            place = 1'b1;
                        else if ((hi - ptr) + (st - lo) > b)
                            bounce = 1'b1;
                    end
                    else if (ptr + b < st)
                        place = 1'b1;
                    // Without reservation support only a single word stays in place
                    if (place && !(ring_cfg.reserve_capable || b <= WORD_BYTES))
                    begin
                        place = 1'b0;
                        bounce = 1'b1;
                    end
                    if (place)
                    begin
                        ring_state.bounce_in_use = 1'b0;
                        ring_state.pending_bytes = bytes;
                        r.status = ST_IN_PLACE;
                        r.write_offset = ring_state.write_pointer;
                        r.reserve_announce = ring_cfg.reserve_capable ? bytes : '0;
                    end
                    else if (bounce)
                    begin
                        ring_state.bounce_in_use = 1'b1;
                        ring_state.pending_bytes = bytes;
                        r.status = ST_BOUNCE;
                    end
                    else
                        r.status = ST_FULL;
                end
            end
            default:
            begin
                // Commit: explicit size, or everything reserved for commit-all
                amount = (op == CMD_COMMIT) ? bytes : ring_state.pending_bytes;
                r.write_offset = ring_state.write_pointer;
                if (ring_state.pending_bytes == 0)
                begin
                    r.status = ST_NO_RESERVE;
                    r.next_offset = ring_state.write_pointer;
                end
                else
                begin
                    ring_state.pending_bytes = '0;
                    if (ring_state.bounce_in_use)
                    begin
                        room = hi - ptr;
                        if (room < 0)
                            room = 0;
                        r.first_chunk_bytes = (longint'(amount) < room) ?
                                              amount : room[OFFSET_BITS-1:0];
                        if (ring_cfg.reserve_capable)
                            r.reserve_announce = amount;
                    end
                    // Single wrap back by the ring span
                    sum = ptr + longint'(amount);
                    if (sum >= hi)
                        sum = sum - (hi - lo);
                    ring_state.write_pointer = sum[OFFSET_BITS-1:0];
                    r.status = ST_COMMITTED;
                    r.next_offset = ring_state.write_pointer;
                end
            end
        endcase
        return r;
    endfunction

    // Watch all three channels on the rising edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        crrc_result_t seen;
        crrc_result_t want;
        if (!rst_n)
        begin
            ring_cfg.ring_min = '0;
            ring_cfg.ring_max = 20'hFFFFF;
            ring_cfg.reserve_capable = 1'b0;
            ring_cfg.bounce_bytes = 20'd1024;
            ring_state = '0;
            replies_due.delete();
            mismatches = 0;
            replies_owed = 0;
        end
        else
        begin
            // Retire the oldest reply first; a word accepted now replies later
            if (result_valid && result_ready)
            begin
                seen.status = status_t'(status);
                seen.write_offset = write_offset;
                seen.next_offset = next_offset;
                seen.reserve_announce = reserve_announce;
                seen.first_chunk_bytes = first_chunk_bytes;
                if (replies_due.size() == 0)
                    note_fault($sformatf("unexpected reply st=%0d wo=%h no=%h",
                                         status, write_offset, next_offset));
                else
                begin
                    want = replies_due.pop_front();
                    if (seen.status !== want.status
                        || seen.write_offset !== want.write_offset
                        || seen.next_offset !== want.next_offset
                        || seen.reserve_announce !== want.reserve_announce
                        || seen.first_chunk_bytes !== want.first_chunk_bytes)
                        note_fault($sformatf(
                            "want st=%0d wo=%h no=%h ann=%h fc=%h got st=%0d wo=%h no=%h ann=%h fc=%h",
                            want.status, want.write_offset, want.next_offset,
                            want.reserve_announce, want.first_chunk_bytes,
                            status, write_offset, next_offset,
                            reserve_announce, first_chunk_bytes));
                end
            end

            // Predict the reply of an accepted command word
            if (item_valid && item_ready)
                replies_due.push_back(advance_ring(cmd_t'(cmd), byte_count, stop_offset));

            // Track register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_RING_MIN:        ring_cfg.ring_min = cfg_data;
                    CFG_RING_MAX:        ring_cfg.ring_max = cfg_data;
                    CFG_RESERVE_CAPABLE: ring_cfg.reserve_capable = cfg_data[0];
                    CFG_BOUNCE_BYTES:    ring_cfg.bounce_bytes = cfg_data;
                    default:             ;
                endcase
            end

            replies_owed = replies_due.size();
        end
    end

endmodule

FILE: tb/sv/command_ring_reserve_commit_top_test.sv
module command_ring_reserve_commit_top_test;
    import crrc_pkg::*;

    localparam int ITEM_TARGET = 550;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_OFFSET  = 20'hFFFFF;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;

    logic                    item_valid = 1'b0;
    logic                    item_ready;
    logic [CMD_BITS-1:0]     cmd = '0;
    logic [OFFSET_BITS-1:0]  byte_count = '0;
    logic [OFFSET_BITS-1:0]  stop_offset = '0;

    logic                    result_valid;
    logic                    result_ready = 1'b0;
    logic [STATUS_BITS-1:0]  status;
    logic [OFFSET_BITS-1:0]  write_offset;
    logic [OFFSET_BITS-1:0]  next_offset;
    logic [OFFSET_BITS-1:0]  reserve_announce;
    logic [OFFSET_BITS-1:0]  first_chunk_bytes;

    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [OFFSET_BITS-1:0]  cfg_data = '0;

    int mismatches;
    int replies_owed;

    // Current register settings, used only to shape stimulus
    int lo_cfg = 0;
    int hi_cfg = MAX_OFFSET;
    int bnc_cfg = 1024;
    bit no_idle = 1'b0;
    int items_sent = 0;
    int stall_left = 0;
    int idle_cycles = 0;

    command_ring_reserve_commit_top DUT (.*);

    crrc_ring_checker u_ring_check (.*);

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Sender gap: mostly none or short, now and then long
    function automatic int pick_pause();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Reservation size: mostly aligned and within the current limits
    function automatic offset_t pick_size();
        int span, lim, r;
        span = (hi_cfg >= lo_cfg) ? hi_cfg - lo_cfg : 0;
        lim = (bnc_cfg < span) ? bnc_cfg : span;
        r = $urandom_range(0, 99);
        if (r < 50)
            return offset_t'(4 * $urandom_range(0, ((lim < 64) ? lim : 64) / 4));
        if (r < 85)
            return offset_t'(4 * $urandom_range(0, lim / 4));
        if (r < 95)
            return offset_t'(lim - lim % 4);
        return offset_t'($urandom);
    endfunction

    // Consumer offset: mostly inside the ring
    function automatic offset_t pick_stop();
        if ($urandom_range(0, 99) < 85 && lo_cfg <= hi_cfg)
            return offset_t'($urandom_range(hi_cfg, lo_cfg));
        return offset_t'($urandom);
    endfunction

    // Present one command word and hold it until accepted
    task automatic send_item(cmd_t op, offset_t bytes, offset_t stop);
        int pause;
        pause = pick_pause();
        if (pause > 0)
        begin
            item_valid <= 1'b0;
            repeat (pause) @(negedge clk);
        end
        cmd <= op;
        byte_count <= bytes;
        stop_offset <= stop;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every reply is back
    task automatic settle();
        item_valid <= 1'b0;
        @(negedge clk);
        while (replies_owed != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, int value);
        cfg_index <= idx;
        cfg_data <= offset_t'(value);
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Write all four registers while the block is idle
    task automatic apply_config(int lo, int hi, int cap, int bnc);
        write_reg(CFG_RING_MIN, lo);
        write_reg(CFG_RING_MAX, hi);
        write_reg(CFG_RESERVE_CAPABLE, cap);
        write_reg(CFG_BOUNCE_BYTES, bnc);
        cfg_valid <= 1'b0;
        @(negedge clk);
        lo_cfg = lo;
        hi_cfg = hi;
        bnc_cfg = bnc;
        no_idle = ($urandom_range(0, 3) == 0);
    endtask

    // Mostly reserve/commit pairs with random content, plus init and noise
    task automatic random_traffic(int count);
        int target, r;
        offset_t size;
        target = items_sent + count;
        while (items_sent < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
                send_item(CMD_INIT, offset_t'($urandom), offset_t'($urandom));
            else if (r < 78)
            begin
                size = pick_size();
                send_item(CMD_RESERVE, size, pick_stop());
                r = $urandom_range(0, 99);
                if (r < 75)
                    send_item(CMD_COMMIT, size, offset_t'($urandom));
                else if (r < 90)
                    send_item(CMD_COMMIT_ALL, offset_t'($urandom), offset_t'($urandom));
                else
                    send_item(CMD_COMMIT, size + offset_t'($urandom_range(1, 7)), '0);
            end
            else
                send_item(cmd_t'($urandom_range(0, 3)),
                          $urandom_range(0, 1) ? offset_t'($urandom)
                                               : offset_t'($urandom_range(0, 64)),
                          pick_stop());
            // Occasionally let the ring drain completely
            if ($urandom_range(0, 39) == 0)
                settle();
        end
    endtask

    // Result side back-pressure
    always @(negedge clk)
    begin : sink_pacing
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            result_ready <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 99) < 25)
        begin
            stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                     : $urandom_range(7, 39);
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    // End the run if no channel moves a word for too long
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin : stimulus
        int lo, hi, span, bnc, r;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Register defaults after reset: large grant goes to bounce
        send_item(CMD_RESERVE, 20'h400, 20'h0);
        send_item(CMD_COMMIT_ALL, 20'h0, 20'h0);
        send_item(CMD_RESERVE, 20'h404, 20'h0);
        settle();

        // Small ring with reservation support
        apply_config(20'h100, 20'h200, 1, 20'h80);
        send_item(CMD_INIT, 20'h0, 20'h0);
        send_item(CMD_COMMIT, 20'h8, 20'h0);
        send_item(CMD_COMMIT_ALL, 20'h0, 20'h0);
        send_item(CMD_RESERVE, 20'h84, 20'h0);
        send_item(CMD_RESERVE, 20'h6, 20'h100);
        send_item(CMD_RESERVE, 20'h0, 20'h100);
        send_item(CMD_COMMIT, 20'h4, 20'h0);
        send_item(CMD_RESERVE, 20'h40, 20'h100);
        send_item(CMD_RESERVE, 20'h8, 20'h100);
        send_item(CMD_COMMIT, 20'h40, 20'h0);
        send_item(CMD_RESERVE, 20'h80, 20'h100);
        send_item(CMD_COMMIT_ALL, 20'hFFFFF, 20'h0);
        send_item(CMD_RESERVE, 20'h80, 20'h180);
        send_item(CMD_COMMIT, 20'h80, 20'h0);
        send_item(CMD_RESERVE, 20'h10, 20'h150);
        send_item(CMD_RESERVE, 20'hC, 20'h150);
        send_item(CMD_COMMIT, 20'h13, 20'h0);
        send_item(CMD_INIT, 20'hFFFFF, 20'hFFFFF);
        send_item(CMD_RESERVE, 20'h80, 20'h180);
        send_item(CMD_COMMIT, 20'h80, 20'h0);
        send_item(CMD_RESERVE, 20'h80, 20'h100);
        send_item(CMD_COMMIT, 20'h80, 20'h0);
        send_item(CMD_RESERVE, 20'h80, 20'h100);
        send_item(CMD_RESERVE, 20'hFFFFF, 20'hFFFFF);
        settle();

        // Same ring without reservation support
        apply_config(20'h100, 20'h200, 0, 20'h100);
        send_item(CMD_INIT, 20'h0, 20'h0);
        send_item(CMD_RESERVE, 20'h4, 20'h100);
        send_item(CMD_COMMIT, 20'h4, 20'h0);
        send_item(CMD_RESERVE, 20'h8, 20'h100);
        send_item(CMD_COMMIT, 20'h8, 20'h0);
        random_traffic(60);
        settle();

        // Register extremes
        apply_config(0, MAX_OFFSET, 1, MAX_OFFSET);
        random_traffic(60);
        settle();
        apply_config(MAX_OFFSET, 0, 0, 0);
        random_traffic(30);
        settle();
        apply_config(20'h40000, 20'h40040, 1, 20'h20);
        random_traffic(60);
        settle();
        apply_config(0, 20'h40, 0, 20'h40);
        random_traffic(60);
        settle();

        // Random small rings anywhere in the offset space
        while (items_sent < ITEM_TARGET)
        begin
            lo = $urandom_range(0, MAX_OFFSET);
            if ($urandom_range(0, 3) != 0)
                lo = lo & ~3;
            span = 4 * $urandom_range(2, 512);
            if ($urandom_range(0, 3) == 0)
                span = span + $urandom_range(1, 3);
            hi = (lo + span > MAX_OFFSET) ? MAX_OFFSET : lo + span;
            r = $urandom_range(0, 9);
            bnc = (r < 4) ? span : (r < 8) ? $urandom_range(0, span)
                                           : $urandom_range(0, MAX_OFFSET);
            apply_config(lo, hi, $urandom_range(0, 1), bnc);
            random_traffic(60);
            settle();
        end

        if (mismatches == 0 && replies_owed == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
